/* design/pglf_pkg.sv */
// Package for pixel_gap_linear_fill: constants, payload structs and sequencer states.
package pglf_pkg;

    localparam int MAX_SCALE = 16;
    localparam int MAX_DIM   = 4096;

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 12;
    localparam int OCOORD_W = 13;
    localparam int CFG_W    = 5;
    localparam int NUM_CH   = 3;
    localparam int CH_W     = 2;
    localparam int BIT_W    = $clog2(PIX_W);
    localparam int K_W      = $clog2(MAX_SCALE) + 1;
    localparam int I_W      = $clog2(MAX_SCALE);

    localparam logic [CFG_W-1:0] SCALE_RESET = CFG_W'(2);

    typedef struct packed {
        logic [PIX_W-1:0]   first_blue;
        logic [PIX_W-1:0]   first_green;
        logic [PIX_W-1:0]   first_red;
        logic [PIX_W-1:0]   second_blue;
        logic [PIX_W-1:0]   second_green;
        logic [PIX_W-1:0]   second_red;
        logic [COORD_W-1:0] base_row;
        logic [COORD_W-1:0] base_col;
        logic               direction;
    } in_t;

    typedef struct packed {
        logic [OCOORD_W-1:0] out_row;
        logic [OCOORD_W-1:0] out_col;
        logic [PIX_W-1:0]    blue;
        logic [PIX_W-1:0]    green;
        logic [PIX_W-1:0]    red;
        logic                last;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

/* design/pixel_gap_linear_fill.sv */
// Top level of pixel_gap_linear_fill: gap filler between two pixels with a shared divider.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  s_      | in        | s_valid / s_ready       | s_data  (in_t, two pixels)
//  m_      | out       | m_valid / m_ready       | m_data  (out_t, one pixel)
//  cfg_    | in        | cfg_wr_en (no wait)     | cfg_wr_data (scale_factor)
//
// An item of scale k gives k-1 results: an accept in idle, then the shared restoring divider
// (8 bits for each of three channels), then one result per cycle into the output register
// while it is free or being drained.
// Scale 0 or 1 consumes the item with no results; scale above MAX_SCALE saturates.
// Reset (aresetn low, synchronous) returns to idle, empties the output register and
// sets scale to 2. A stall on m_ready holds the emit sequence; s_ready is high only idle.
module pixel_gap_linear_fill
    import pglf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    // Configuration register and its saturated view.
    logic [CFG_W-1:0] scale_reg;
    logic [K_W-1:0]   k_sat;

    // Sequencer.
    state_t state_reg, state_next;
    logic   load;          // move one result into the output register
    logic   in_xfer;       // input transfer this cycle
    logic   run_ok;        // saturated scale gives a non-empty run

    // Item held for the whole run.
    logic [PIX_W-1:0]   a_reg   [NUM_CH];
    logic [PIX_W-1:0]   b_reg   [NUM_CH];
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic               dir_reg;
    logic [K_W-1:0]     k_reg;

    // Divider and per-channel results.
    logic [CH_W-1:0]  ch_reg;
    logic [BIT_W-1:0] bit_reg;
    logic [K_W-1:0]   rem_reg;
    logic [PIX_W-1:0] q_reg;
    logic [PIX_W-1:0] step_reg [NUM_CH];
    logic [PIX_W-1:0] acc_reg  [NUM_CH];
    logic             desc_reg [NUM_CH];

    // Emit counter, position i = 1 .. k-1.
    logic [I_W-1:0] i_reg;

    // Output register.
    logic m_valid_reg;
    out_t m_data_reg;

    // Divider datapath signals.
    logic [PIX_W-1:0] cur_a, cur_b, cur_diff;
    logic             cur_desc;
    logic [K_W-1:0]   rem_in;
    logic [K_W:0]     partial;
    logic             q_bit;
    logic [K_W-1:0]   rem_new;
    logic [PIX_W-1:0] q_new;
    logic             div_last_bit;

    // Emit datapath signals.
    logic [PIX_W-1:0]    acc_next [NUM_CH];
    logic                out_last;
    logic [OCOORD_W-1:0] row_out, col_out;

    assign in_xfer = s_valid && s_ready;
    assign k_sat   = (int'(scale_reg) > MAX_SCALE) ? K_W'(MAX_SCALE) : K_W'(scale_reg);
    assign run_ok  = (k_sat >= K_W'(2));

    // Configuration write, taken at any edge with the enable high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            scale_reg <= cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------------
    // Shared divider step: one quotient bit of |a-b| / k for the current channel.
    // Bits go from MSB to LSB; the partial remainder starts at zero on the MSB.
    // ---------------------------------------------------------------------
    assign cur_a        = a_reg[ch_reg];
    assign cur_b        = b_reg[ch_reg];
    assign cur_desc     = (cur_a > cur_b);
    assign cur_diff     = cur_desc ? (cur_a - cur_b) : (cur_b - cur_a);
    assign rem_in       = (bit_reg == BIT_W'(PIX_W - 1)) ? '0 : rem_reg;
    assign partial      = {rem_in, cur_diff[bit_reg]};
    assign q_bit        = (partial >= {1'b0, k_reg});
    assign rem_new      = q_bit ? K_W'(partial - {1'b0, k_reg}) : K_W'(partial);
    assign q_new        = {q_reg[PIX_W-2:0], q_bit};
    assign div_last_bit = (bit_reg == '0);

    // ---------------------------------------------------------------------
    // Emit step: rising runs add the step from min, falling runs start at
    // min + step*k (= first value - remainder) and subtract the step.
    // ---------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            acc_next[c] = desc_reg[c] ? (acc_reg[c] - step_reg[c])
                                      : (acc_reg[c] + step_reg[c]);
        end
    end

    assign out_last = (K_W'(i_reg) == (k_reg - K_W'(1)));
    assign row_out  = dir_reg ? (OCOORD_W'(row_reg) + OCOORD_W'(i_reg)) : OCOORD_W'(row_reg);
    assign col_out  = dir_reg ? OCOORD_W'(col_reg) : (OCOORD_W'(col_reg) + OCOORD_W'(i_reg));

    // ---------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && run_ok) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_last_bit && (ch_reg == CH_W'(NUM_CH - 1))) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load && out_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_ready = 1'b0;
        load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_DIV:  ;
            ST_EMIT: load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item capture, divider registers and accumulators (payload, no reset).
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            a_reg[0] <= s_data.first_blue;
            a_reg[1] <= s_data.first_green;
            a_reg[2] <= s_data.first_red;
            b_reg[0] <= s_data.second_blue;
            b_reg[1] <= s_data.second_green;
            b_reg[2] <= s_data.second_red;
            row_reg  <= s_data.base_row;
            col_reg  <= s_data.base_col;
            dir_reg  <= s_data.direction;
            k_reg    <= k_sat;
            ch_reg   <= '0;
            bit_reg  <= BIT_W'(PIX_W - 1);
            i_reg    <= I_W'(1);
        end
        if (state_reg == ST_DIV) begin
            rem_reg <= rem_new;
            q_reg   <= q_new;
            bit_reg <= bit_reg - BIT_W'(1);
            if (div_last_bit) begin
                // Close this channel: store step and seed the accumulator.
                step_reg[ch_reg] <= q_new;
                desc_reg[ch_reg] <= cur_desc;
                acc_reg[ch_reg]  <= cur_desc ? (cur_a - PIX_W'(rem_new)) : cur_a;
                ch_reg           <= ch_reg + CH_W'(1);
            end
        end
        if (load) begin
            for (int c = 0; c < NUM_CH; c++) begin
                acc_reg[c] <= acc_next[c];
            end
            i_reg <= i_reg + I_W'(1);
        end
    end

    // Output register: load one result whenever the slot is free or being drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.out_row <= row_out;
            m_data_reg.out_col <= col_out;
            m_data_reg.blue    <= acc_next[0];
            m_data_reg.green   <= acc_next[1];
            m_data_reg.red     <= acc_next[2];
            m_data_reg.last    <= out_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_start_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && run_ok) |=> (state_reg == ST_DIV))
        else $error("accepted item with a valid scale did not start the divider");

    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && out_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last result");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ((i_reg != '0) && (K_W'(i_reg) < k_reg)))
        else $error("emit position left the range 1 .. k-1");

endmodule

/* dv/pixel_gap_linear_fill_test.sv */
// Self-checking testbench for pixel_gap_linear_fill: queued pixel pairs, predicted fill runs.
module pixel_gap_linear_fill_test;
    import pglf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    // Worst item: accept, the divider over all three channels, 15 results; pad for the output register.
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PHASES = 8;
    localparam int PAIRS_PER_PHASE = 18;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_t              s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_t             m_data;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    // Pixel pairs waiting for the driver, and fill pixels predicted but not yet seen.
    in_t  pair_queue[$];
    out_t fill_due[$];
    out_t fill_head;

    // Scale as the block holds it; the block resets to two.
    logic [CFG_W-1:0] scale_now = SCALE_RESET;

    int pairs_sent     = 0;
    int pairs_taken    = 0;
    int fails          = 0;
    int cycle_count    = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    pixel_gap_linear_fill dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // One channel of the run: truncated step from the smaller value, reversed when the
    // first value is larger.
    function automatic logic [PIX_W-1:0] lerp_channel(int a, int b, int k, int i);
        int lo;
        int diff;
        int pos;
        lo   = (a < b) ? a : b;
        diff = (a < b) ? b - a : a - b;
        pos  = (a > b) ? k - i : i;
        return PIX_W'(lo + (diff / k) * pos);
    endfunction

    // Queue the k-1 fill pixels that one accepted pair must produce at the current scale.
    function automatic void predict_fill_run(in_t p);
        int   k;
        out_t o;
        k = int'(scale_now);
        if (k < 2) return;
        if (k > MAX_SCALE) k = MAX_SCALE;
        for (int i = 1; i < k; i++) begin
            o.out_row = p.direction ? OCOORD_W'(p.base_row + i) : OCOORD_W'(p.base_row);
            o.out_col = p.direction ? OCOORD_W'(p.base_col) : OCOORD_W'(p.base_col + i);
            o.blue    = lerp_channel(int'(p.first_blue), int'(p.second_blue), k, i);
            o.green   = lerp_channel(int'(p.first_green), int'(p.second_green), k, i);
            o.red     = lerp_channel(int'(p.first_red), int'(p.second_red), k, i);
            o.last    = (i == k - 1);
            fill_due.push_back(o);
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    function automatic in_t make_pair(int fb, int fg, int fr, int sb, int sg, int sr,
                                      int row, int col, bit dir);
        in_t p;
        p.first_blue   = PIX_W'(fb);
        p.first_green  = PIX_W'(fg);
        p.first_red    = PIX_W'(fr);
        p.second_blue  = PIX_W'(sb);
        p.second_green = PIX_W'(sg);
        p.second_red   = PIX_W'(sr);
        p.base_row     = COORD_W'(row);
        p.base_col     = COORD_W'(col);
        p.direction    = dir;
        return p;
    endfunction

    // Lean channel values toward the rails so that full-range differences show up often.
    function automatic int pick_level();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return (1 << COORD_W) - 1;
            default: return $urandom_range(0, (1 << COORD_W) - 1);
        endcase
    endfunction

    function automatic in_t random_pair();
        in_t p;
        p = make_pair(pick_level(), pick_level(), pick_level(),
                      pick_level(), pick_level(), pick_level(),
                      pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
        // Flat gaps: a second pixel equal to the first gives a zero step everywhere.
        if ($urandom_range(0, 7) == 0) begin
            p.second_blue  = p.first_blue;
            p.second_green = p.first_green;
            p.second_red   = p.first_red;
        end
        return p;
    endfunction

    // Change the scale only while the block is idle; track it for the predictor.
    task automatic write_scale(input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scale_now = value;
    endtask

    task automatic send_pair(input in_t p);
        pair_queue.push_back(p);
        pairs_sent++;
    endtask

    // Wait until every pair has transferred and every fill pixel has arrived, then let
    // the block settle back to idle.
    task automatic drain();
        while (pairs_taken != pairs_sent || fill_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Driver: record each transfer for prediction, then present the next pair or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_fill_run(s_data);
                pairs_taken++;
            end
            // Hold valid and payload until the pending transfer completes.
            if (!s_valid || s_ready) begin
                if (pair_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pair_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each fill pixel transfer with the oldest prediction, stall at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (fill_due.size() == 0) begin
                    $error("fill pixel with none predicted: row %0d col %0d",
                           m_data.out_row, m_data.out_col);
                    fails++;
                end else begin
                    fill_head = fill_due.pop_front();
                    check_field("out_row", 16'(fill_head.out_row), 16'(m_data.out_row));
                    check_field("out_col", 16'(fill_head.out_col), 16'(m_data.out_col));
                    check_field("blue", 16'(fill_head.blue), 16'(m_data.blue));
                    check_field("green", 16'(fill_head.green), 16'(m_data.green));
                    check_field("red", 16'(fill_head.red), 16'(m_data.red));
                    check_field("last", 16'(fill_head.last), 16'(m_data.last));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        in_t              corner_pairs[6];
        logic [CFG_W-1:0] scale_pick;

        // Rails, rising and falling runs, mixed ordering per channel, edge coordinates.
        corner_pairs[0] = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        corner_pairs[1] = make_pair(255, 255, 255, 255, 255, 255, 4095, 4095, 1'b1);
        corner_pairs[2] = make_pair(0, 0, 0, 255, 255, 255, 4095, 4095, 1'b0);
        corner_pairs[3] = make_pair(255, 255, 255, 0, 0, 0, 4095, 0, 1'b1);
        corner_pairs[4] = make_pair(10, 200, 77, 250, 3, 77, 2048, 1365, 1'b0);
        corner_pairs[5] = make_pair(1, 254, 128, 254, 1, 127, 0, 4095, 1'b1);

        // Hold reset low first, then release it for good.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_gap_pct   = 24;
        recv_stall_pct = 46;

        // Directed: corner pairs at the reset scale and at the largest scale.
        foreach (corner_pairs[n]) send_pair(corner_pairs[n]);
        drain();
        write_scale(CFG_W'(MAX_SCALE));
        foreach (corner_pairs[n]) send_pair(corner_pairs[n]);
        drain();

        // Scale zero and one: pairs are consumed and produce no fill pixels.
        write_scale('0);
        send_pair(corner_pairs[2]);
        send_pair(corner_pairs[3]);
        drain();
        write_scale(CFG_W'(1));
        send_pair(corner_pairs[1]);
        send_pair(corner_pairs[4]);
        drain();

        // All-ones scale: saturate to the largest run.
        write_scale('1);
        send_pair(corner_pairs[2]);
        send_pair(corner_pairs[3]);
        send_pair(corner_pairs[5]);
        drain();

        // Random: mostly legal scales, now and then below two or above the limit.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 3) begin
                send_gap_pct   = 24;
                recv_stall_pct = 46;
            end else if (ph < 6) begin
                send_gap_pct   = 46;
                recv_stall_pct = 24;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            case ($urandom_range(0, 9))
                0: scale_pick = CFG_W'($urandom_range(0, 1));
                1: scale_pick = CFG_W'($urandom_range(MAX_SCALE + 1, (1 << CFG_W) - 1));
                default: scale_pick = CFG_W'($urandom_range(2, MAX_SCALE));
            endcase
            write_scale(scale_pick);
            for (int n = 0; n < PAIRS_PER_PHASE; n++) send_pair(random_pair());
            drain();
        end

        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* pixel_gap_linear_fill.f */
design/pglf_pkg.sv
design/pixel_gap_linear_fill.sv
dv/pixel_gap_linear_fill_test.sv
